@@ sv/he_pkg.sv @@
package he_pkg;

   // widths of the data path
   localparam int COUNT_BITS  = 24;
   localparam int LEVELS      = 256;
   localparam int LEVEL_BITS  = $clog2(LEVELS);
   localparam int SAMPLE_BITS = 8;
   localparam int CFG_BITS    = 24;
   localparam int THR_BITS    = COUNT_BITS + 9;
   localparam int WIDE_BITS   = ((CFG_BITS > COUNT_BITS) ? CFG_BITS : COUNT_BITS) + 1;

   localparam logic [CFG_BITS-1:0]   CFG_RESET = CFG_BITS'(65536);
   localparam logic [WIDE_BITS-1:0]  COUNT_MAX =
      (WIDE_BITS'(1) << COUNT_BITS) - WIDE_BITS'(1);
   localparam logic [LEVEL_BITS-1:0] TOP_LEVEL = LEVEL_BITS'(LEVELS - 1);

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [LEVEL_BITS-1:0] bin_type;

   // control of the bin count store
   typedef struct packed {
      logic    count_en;
      logic    read_en;
      bin_type bin;
      logic    clear_all;
   } hist_ctrl_type;

   // write into the level table
   typedef struct packed {
      logic                   en;
      bin_type                addr;
      logic [SAMPLE_BITS-1:0] data;
   } map_wr_type;

   // pixel count as used: zero counts as one, saturated to the counter range
   function automatic count_type effective_count(input logic [CFG_BITS-1:0] cfg);
      logic [WIDE_BITS-1:0] v;
      v = WIDE_BITS'(cfg);
      if (v == '0) begin
         v = WIDE_BITS'(1);
      end
      if (v > COUNT_MAX) begin
         v = COUNT_MAX;
      end
      return v[COUNT_BITS-1:0];
   endfunction

endpackage

@@ sv/he_ram.sv @@
module he_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read returning the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/he_hist.sv @@
module he_hist (
   input  logic                  clock,
   input  logic                  reset,
   input  he_pkg::hist_ctrl_type ctrl,
   output he_pkg::count_type     read_data
);

   import he_pkg::*;

   logic [LEVELS-1:0] valid_ff;
   logic [LEVELS-1:0] valid_in;
   logic              s1_valid_ff;
   bin_type           s1_bin_ff;
   logic              rd_vbit_ff;
   logic              last_valid_ff;
   bin_type           last_bin_ff;
   count_type         last_data_ff;
   count_type         ram_data;
   count_type         stored;
   count_type         old_count;
   count_type         new_count;
   logic              rd_en;

   assign rd_en = ctrl.count_en | ctrl.read_en;

   // bins never written since the last clear read as zero
   assign stored    = rd_vbit_ff ? ram_data : '0;
   assign read_data = stored;

   // forward the write that landed on the edge of our read
   assign old_count = (last_valid_ff && (last_bin_ff == s1_bin_ff)) ? last_data_ff : stored;
   assign new_count = (old_count != '1) ? old_count + COUNT_BITS'(1) : old_count;

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear_all) begin
         valid_in = '0;
      end else if (s1_valid_ff) begin
         valid_in[s1_bin_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         last_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         s1_valid_ff   <= ctrl.count_en;
         last_valid_ff <= s1_valid_ff;
      end
   end

   // payload of the increment stage
   always_ff @(posedge clock) begin
      s1_bin_ff    <= ctrl.bin;
      last_bin_ff  <= s1_bin_ff;
      last_data_ff <= new_count;
      if (rd_en) begin
         rd_vbit_ff <= valid_ff[ctrl.bin];
      end
   end

   he_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(LEVELS)
   ) u_bin_ram (
      .clock  (clock),
      .wr_en  (s1_valid_ff),
      .wr_addr(s1_bin_ff),
      .wr_data(new_count),
      .rd_en  (rd_en),
      .rd_addr(ctrl.bin),
      .rd_data(ram_data)
   );

endmodule

@@ sv/he_map_build.sv @@
module he_map_build (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  build_start,
   input  he_pkg::count_type     pixels,
   input  he_pkg::count_type     bin_data,
   output he_pkg::hist_ctrl_type hist_rd,
   output he_pkg::map_wr_type    map_wr,
   output logic                  done
);

   import he_pkg::*;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_READ = 2'd1;
   localparam logic [1:0] B_ACC  = 2'd2;
   localparam logic [1:0] B_STEP = 2'd3;

   logic [1:0]          state_ff, state_in;
   bin_type             bin_ff, bin_in;
   count_type           cum_ff, cum_in;
   bin_type             level_ff, level_in;
   logic [THR_BITS-1:0] thr_ff, thr_in;
   count_type           n_ff, n_in;

   logic [COUNT_BITS:0] sum;
   count_type           clamped;
   logic [THR_BITS-1:0] scaled;
   logic                step_up;
   logic                last_bin;
   logic                bin_done;

   // cumulative count, never above the pixel count
   assign sum     = {1'b0, cum_ff} + {1'b0, bin_data};
   assign clamped = (sum >= {1'b0, n_ff}) ? n_ff : sum[COUNT_BITS-1:0];

   // level L+1 is reached once 510*cum >= n*(2L+1); thr holds n*(2L+1)
   assign scaled   = (THR_BITS'(cum_ff) << 9) - (THR_BITS'(cum_ff) << 1);
   assign step_up  = (scaled >= thr_ff) && (level_ff != TOP_LEVEL);
   assign last_bin = (bin_ff == bin_type'(LEVELS - 1));
   assign bin_done = (state_ff == B_STEP) && !step_up;

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      cum_in   = cum_ff;
      level_in = level_ff;
      thr_in   = thr_ff;
      n_in     = n_ff;
      case (state_ff)
         B_IDLE: begin
            if (build_start) begin
               state_in = B_READ;
               bin_in   = '0;
               cum_in   = '0;
               level_in = '0;
               thr_in   = THR_BITS'(pixels);
               n_in     = pixels;
            end
         end
         B_READ: begin
            state_in = B_ACC;
         end
         B_ACC: begin
            cum_in   = clamped;
            state_in = B_STEP;
         end
         B_STEP: begin
            if (step_up) begin
               level_in = level_ff + LEVEL_BITS'(1);
               thr_in   = thr_ff + (THR_BITS'(n_ff) << 1);
            end else if (last_bin) begin
               state_in = B_IDLE;
            end else begin
               bin_in   = bin_ff + LEVEL_BITS'(1);
               state_in = B_READ;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      cum_ff   <= cum_in;
      level_ff <= level_in;
      thr_ff   <= thr_in;
      n_ff     <= n_in;
   end

   // bin reads, table writes and the clear after the last bin
   always_comb begin
      hist_rd.count_en  = 1'b0;
      hist_rd.read_en   = (state_ff == B_READ);
      hist_rd.bin       = bin_ff;
      hist_rd.clear_all = bin_done && last_bin;
      map_wr.en         = bin_done;
      map_wr.addr       = bin_ff;
      map_wr.data       = SAMPLE_BITS'(level_ff);
   end

   assign done = bin_done && last_bin;

endmodule

@@ sv/histogram_equalizer.sv @@
// Histogram equalizer for 8-bit samples.
// Each image is sent twice on the req_ channel: an item is taken on a rising
// edge with start high and busy low. In the counting pass every item is
// counted into a 256-bin histogram and gives no result. The pass ends after
// the number of items held in the pixel count register (csr_write_enable and
// csr_write_data; zero counts as one). The level table is then built while
// busy is high: after the drain state each bin is read, accumulated and
// stepped, plus a step per output level reached, through the single read
// port of the bin store and one compare per step. In the mapping pass every
// item is looked up in the table and its result appears in the next cycle
// with rsp_strobe high for one cycle; rsp_end_of_image marks the last one.
// Counting and mapping take one item per cycle; bin increments go through a
// read-modify-write of the bin memory with forwarding between neighbours.
// The receiver cannot hold results off, so nothing ever waits on it.
// Reset returns to the counting pass with an empty histogram and a pixel
// count of 65536; the bins are cleared at once after each table build.
module histogram_equalizer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [he_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                        rsp_strobe,
   output logic [he_pkg::SAMPLE_BITS-1:0] rsp_mapped_sample,
   output logic                        rsp_end_of_image,
   input  logic                        csr_write_enable,
   input  logic [he_pkg::CFG_BITS-1:0] csr_write_data
);

   import he_pkg::*;

   localparam logic [1:0] S_COUNT = 2'd0;
   localparam logic [1:0] S_DRAIN = 2'd1;
   localparam logic [1:0] S_BUILD = 2'd2;
   localparam logic [1:0] S_MAP   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CFG_BITS-1:0] cfg_ff;
   count_type           index_ff, index_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                rsp_end_ff, rsp_end_in;

   count_type     n_eff;
   logic          accept;
   logic          last;
   hist_ctrl_type build_hist;
   hist_ctrl_type hist_ctrl;
   count_type     bin_data;
   map_wr_type    map_wr;
   logic          build_done;

   assign busy   = (state_ff == S_DRAIN) || (state_ff == S_BUILD);
   assign accept = start && !busy;
   assign n_eff  = effective_count(cfg_ff);
   assign last   = ({1'b0, index_ff} + (COUNT_BITS + 1)'(1)) >= {1'b0, n_eff};

   // pass control and item index
   always_comb begin
      state_in      = state_ff;
      index_in      = index_ff;
      rsp_strobe_in = 1'b0;
      rsp_end_in    = 1'b0;
      case (state_ff)
         S_COUNT: begin
            if (accept) begin
               if (last) begin
                  state_in = S_DRAIN;
                  index_in = '0;
               end else begin
                  index_in = index_ff + COUNT_BITS'(1);
               end
            end
         end
         S_DRAIN: begin
            state_in = S_BUILD;
         end
         S_BUILD: begin
            if (build_done) begin
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               rsp_end_in    = last;
               if (last) begin
                  state_in = S_COUNT;
                  index_in = '0;
               end else begin
                  index_in = index_ff + COUNT_BITS'(1);
               end
            end
         end
         default: begin
            state_in = S_COUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_COUNT;
         index_ff      <= '0;
         cfg_ff        <= CFG_RESET;
         rsp_strobe_ff <= 1'b0;
         rsp_end_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         index_ff      <= index_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_end_ff    <= rsp_end_in;
         if (csr_write_enable) begin
            cfg_ff <= csr_write_data;
         end
      end
   end

   // counting items share the bin store port with the table build
   always_comb begin
      hist_ctrl = build_hist;
      if (accept && (state_ff == S_COUNT)) begin
         hist_ctrl.count_en = 1'b1;
         hist_ctrl.bin      = bin_type'(req_sample);
      end
   end

   he_hist u_hist (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (hist_ctrl),
      .read_data(bin_data)
   );

   he_map_build u_build (
      .clock      (clock),
      .reset      (reset),
      .build_start(state_ff == S_DRAIN),
      .pixels     (n_eff),
      .bin_data   (bin_data),
      .hist_rd    (build_hist),
      .map_wr     (map_wr),
      .done       (build_done)
   );

   // level table, looked up in the mapping pass
   he_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(LEVELS)
   ) u_level_ram (
      .clock  (clock),
      .wr_en  (map_wr.en),
      .wr_addr(map_wr.addr),
      .wr_data(map_wr.data),
      .rd_en  (accept && (state_ff == S_MAP)),
      .rd_addr(bin_type'(req_sample)),
      .rd_data(rsp_mapped_sample)
   );

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_end_of_image = rsp_end_ff;

   // checks
   a_rsp_follows_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("result without an item taken in the mapping pass");

   a_end_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_end_of_image |-> rsp_strobe)
      else $error("end of image flag without a result");

   a_table_write_in_build: assert property (@(posedge clock) disable iff (reset)
      map_wr.en |-> (state_ff == S_BUILD))
      else $error("level table written outside the build");

   a_drain_to_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |=> (state_ff == S_BUILD))
      else $error("drain cycle not followed by the table build");

endmodule

@@ bench/tb_histogram_equalizer.sv @@
module tb_histogram_equalizer;
   import he_pkg::*;

   localparam int SETTLE_CYCLES = 1100;
   localparam int TARGET_ITEMS  = 1125;
   localparam int DIRECTED_ROWS = 29;
   localparam logic [COUNT_BITS:0] COUNT_CEILING = {1'b0, {COUNT_BITS{1'b1}}};

   typedef enum logic {ROW_WRITE_COUNT, ROW_PIXEL} row_kind_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] level;
      logic                   last;
   } level_result_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CFG_BITS-1:0]    value;
      logic                   typed;
      logic [SAMPLE_BITS-1:0] want_level;
      logic                   want_last;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [SAMPLE_BITS-1:0] req_sample;
   logic                   rsp_strobe;
   logic [SAMPLE_BITS-1:0] rsp_mapped_sample;
   logic                   rsp_end_of_image;
   logic                   csr_write_enable;
   logic [CFG_BITS-1:0]    csr_write_data;

   // equaliser state as predicted
   count_type              bin_tally [LEVELS];
   logic [SAMPLE_BITS-1:0] level_lut [LEVELS];
   count_type              sample_pos;
   logic                   in_mapping;
   logic [CFG_BITS-1:0]    count_reg;

   level_result_type pending_levels [$];
   int               mismatch_count;
   int               items_sent;

   histogram_equalizer dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_sample        (req_sample),
      .rsp_strobe        (rsp_strobe),
      .rsp_mapped_sample (rsp_mapped_sample),
      .rsp_end_of_image  (rsp_end_of_image),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // one accepted item through the predicted equaliser
   task automatic equalize_step(input logic [SAMPLE_BITS-1:0] pix, output bit produced,
                                output level_result_type res);
      logic [COUNT_BITS:0] n_wide;
      count_type           n;
      bit                  last;
      longint unsigned     cum;
      n_wide = {1'b0, count_reg};
      if (n_wide == '0) begin
         n_wide = (COUNT_BITS + 1)'(1);
      end
      if (n_wide > COUNT_CEILING) begin
         n_wide = COUNT_CEILING;
      end
      n = n_wide[COUNT_BITS-1:0];
      last = ({1'b0, sample_pos} + 1'b1 >= n_wide);
      produced = 1'b0;
      res = '0;
      if (!in_mapping) begin
         if (bin_tally[pix] != '1) begin
            bin_tally[pix]++;
         end
         if (last) begin
            // cumulative table, rounded half up
            cum = 0;
            for (int b = 0; b < LEVELS; b++) begin
               cum += bin_tally[b];
               if (cum > n) begin
                  cum = n;
               end
               level_lut[b] = SAMPLE_BITS'((cum * 510 + n) / (2 * n));
            end
            in_mapping = 1'b1;
            sample_pos = '0;
         end else begin
            sample_pos++;
         end
      end else begin
         produced = 1'b1;
         res.level = level_lut[pix];
         res.last = last;
         if (last) begin
            foreach (bin_tally[b]) begin
               bin_tally[b] = '0;
            end
            in_mapping = 1'b0;
            sample_pos = '0;
         end else begin
            sample_pos++;
         end
      end
   endtask

   // hold off the sender until all results are in, optionally let the block go quiet
   task automatic settle_block(input bit full);
      @(negedge clock);
      start = 1'b0;
      while (pending_levels.size() != 0) begin
         @(posedge clock);
      end
      if (full) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   task automatic write_pixel_count(input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      count_reg = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // offer one item after a gap, wait for acceptance, log what it should give
   task automatic send_pixel(input logic [SAMPLE_BITS-1:0] pix, input int gap,
                             input bit typed, input level_result_type want);
      bit               produced;
      level_result_type res;
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_sample = pix;
      do @(posedge clock); while (busy);
      equalize_step(pix, produced, res);
      if (produced) begin
         pending_levels.push_back(typed ? want : res);
      end
      items_sent++;
   endtask

   // result checker
   always @(posedge clock) begin
      level_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual level %0d last %0b",
                     $time, rsp_mapped_sample, rsp_end_of_image);
            mismatch_count++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_mapped_sample !== want.level) begin
               $display("%0t: mapped_sample mismatch: expected %0d, actual %0d",
                        $time, want.level, rsp_mapped_sample);
               mismatch_count++;
            end
            if (rsp_end_of_image !== want.last) begin
               $display("%0t: end_of_image mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_end_of_image);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type           directed_rows [DIRECTED_ROWS];
      level_result_type       want;
      int                     img_pixels;
      int                     content_mode;
      int                     gap_mode;
      int                     gap;
      int                     base;
      bit                     pressure_done;
      logic [CFG_BITS-1:0]    cfg_value;
      logic [SAMPLE_BITS-1:0] pix;

      reset = 1'b1;
      start = 1'b0;
      req_sample = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      count_reg = CFG_BITS'(65536);
      foreach (bin_tally[b]) begin
         bin_tally[b] = '0;
         level_lut[b] = '0;
      end
      sample_pos = '0;
      in_mapping = 1'b0;
      mismatch_count = 0;
      items_sent = 0;
      pressure_done = 1'b0;

      // single-pixel images map to full black or full white; zero counts as one; then two- and four-pixel images
      directed_rows = '{
         '{ROW_WRITE_COUNT, 24'd1, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd0, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd0, 1'b1, 8'd255, 1'b1},
         '{ROW_PIXEL, 24'd255, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd254, 1'b1, 8'd0, 1'b1},
         '{ROW_WRITE_COUNT, 24'd0, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd128, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd128, 1'b1, 8'd255, 1'b1},
         '{ROW_PIXEL, 24'd200, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd7, 1'b1, 8'd0, 1'b1},
         '{ROW_WRITE_COUNT, 24'd2, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd0, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd255, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd0, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd255, 1'b1, 8'd255, 1'b1},
         '{ROW_WRITE_COUNT, 24'd4, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd0, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd0, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd0, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd0, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd0, 1'b1, 8'd255, 1'b0},
         '{ROW_PIXEL, 24'd255, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd17, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd0, 1'b1, 8'd255, 1'b1},
         '{ROW_WRITE_COUNT, 24'hFFFFFF, 1'b0, 8'd0, 1'b0},
         '{ROW_WRITE_COUNT, 24'd3, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd255, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd128, 1'b0, 8'd0, 1'b0},
         '{ROW_PIXEL, 24'd1, 1'b0, 8'd0, 1'b0}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_WRITE_COUNT) begin
            settle_block(1'b1);
            write_pixel_count(directed_rows[r].value);
         end else begin
            want = '{directed_rows[r].want_level, directed_rows[r].want_last};
            send_pixel(directed_rows[r].value[SAMPLE_BITS-1:0], $urandom_range(0, 12),
                       directed_rows[r].typed, want);
         end
      end
      // finish the three-pixel image from the table
      send_pixel(8'd0, 0, 1'b0, '0);
      send_pixel(8'd1, 3, 1'b0, '0);
      send_pixel(8'd128, 0, 1'b0, '0);

      // random images, mostly small, now and then a larger one
      while (items_sent < TARGET_ITEMS) begin
         img_pixels = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 24);
         if ($urandom_range(0, 15) == 0) begin
            img_pixels = $urandom_range(100, 300);
         end
         cfg_value = CFG_BITS'(img_pixels);
         if (img_pixels == 1 && $urandom_range(0, 1) == 1) begin
            cfg_value = '0;
         end
         if (cfg_value != count_reg) begin
            settle_block(1'b1);
            write_pixel_count(cfg_value);
         end
         content_mode = $urandom_range(0, 4);
         gap_mode = $urandom_range(0, 2);
         base = $urandom_range(0, 255);
         for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < img_pixels; i++) begin
               // pixel content by image flavour
               case (content_mode)
                  0: begin
                     pix = SAMPLE_BITS'($urandom_range(0, 255));
                  end
                  1: begin
                     pix = SAMPLE_BITS'(base);
                  end
                  2: begin
                     pix = SAMPLE_BITS'(base ^ $urandom_range(0, 7));
                  end
                  3: begin
                     pix = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                  end
                  default: begin
                     pix = ($urandom_range(0, 1) == 1) ? SAMPLE_BITS'(base)
                                                       : ~SAMPLE_BITS'(base);
                  end
               endcase
               if (pass == 1 && $urandom_range(0, 3) == 0) begin
                  pix = SAMPLE_BITS'($urandom_range(0, 255));
               end
               // sender gaps, none at all in burst images
               case (gap_mode)
                  0: begin
                     gap = 0;
                  end
                  1: begin
                     gap = $urandom_range(0, 12);
                  end
                  default: begin
                     gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : 0;
                  end
               endcase
               // drain mid mapping pass now and then
               if (pass == 1 && img_pixels >= 4 && i == img_pixels / 2
                   && (!pressure_done || $urandom_range(0, 11) == 0)) begin
                  settle_block(1'b0);
                  pressure_done = 1'b1;
               end
               send_pixel(pix, gap, 1'b0, '0);
            end
         end
      end

      settle_block(1'b1);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
